### sv/fdc_regs_pkg.sv
`default_nettype none

package fdc_regs_pkg;

  typedef enum logic [1:0] {
    REQ_CRU_RD = 2'd0,
    REQ_CRU_WR = 2'd1,
    REQ_MEM_RD = 2'd2,
    REQ_MEM_WR = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    CMD_RESTORE  = 3'd0,
    CMD_STEP     = 3'd1,
    CMD_STEP_IN  = 3'd2,
    CMD_STEP_OUT = 3'd3
  } cmd_e;

  typedef enum logic [1:0] {
    WR_COMMAND = 2'd0,
    WR_TRACK   = 2'd1,
    WR_SECTOR  = 2'd2,
    WR_DATA    = 2'd3
  } wr_sel_e;

  typedef enum logic [2:0] {
    CRU_ROM    = 3'd0,
    CRU_DRV0   = 3'd1,
    CRU_DRV1   = 3'd2,
    CRU_DRV2   = 3'd3,
    CRU_SEL0   = 3'd4,
    CRU_SEL1   = 3'd5,
    CRU_SEL2   = 3'd6,
    CRU_SIDE   = 3'd7
  } cru_bit_e;

  localparam logic [15:0] WinCmd    = 16'h5FF8;
  localparam logic [15:0] WinStatus = 16'h5FF0;
  localparam logic [15:0] WinTrack  = 16'h5FF2;
  localparam logic [15:0] WinSector = 16'h5FF4;
  localparam logic [15:0] WinData   = 16'h5FF6;
  localparam logic [7:0]  StBase    = 8'h20;
  localparam logic [7:0]  StTrk0    = 8'h04;
  localparam logic [7:0]  TrackMax  = 8'hFF;
  localparam logic [7:0]  ReadHigh  = 8'hFF;
  localparam int unsigned CmdUpdBit = 4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  wdata;
  } req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       rom_mapped;
    logic [1:0] drive_now;
    logic       side_now;
  } res_t;

endpackage

`default_nettype wire

### sv/floppy_controller_registers_unit.sv
// An accepted transaction is captured in the input register (item_q, valid_q), and its
// result is then registered in res_q and driven on res_o together with res_valid_o.
// Throughput: one transaction per cycle; busy is never raised.
// The input register and the result register bound the single pass of logic.
// Reset clears all controller registers and the valid flags; the receiver cannot stall.
`default_nettype none

module floppy_controller_registers_unit (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start,
  output logic                 busy,
  input  fdc_regs_pkg::req_t   req_i,
  output logic                 res_valid_o,
  output fdc_regs_pkg::res_t   res_o
);

  logic               valid_q;
  fdc_regs_pkg::req_t item_q;
  logic               res_valid_q;
  fdc_regs_pkg::res_t res_q;

  logic [7:0] track_q, track_d;
  logic [7:0] sector_q, sector_d;
  logic [7:0] data_q, data_d;
  logic       dir_q, dir_d;
  logic [1:0] drive_q, drive_d;
  logic       side_q, side_d;
  logic       rom_q, rom_d;
  logic [7:0] rdata;

  logic [7:0] track_up;
  logic [7:0] track_dn;
  logic [2:0] cru_bit;
  logic [15:0] even_addr;
  logic       upd;

  assign busy = 1'b0;

  assign track_up  = (track_q != fdc_regs_pkg::TrackMax) ? track_q + 8'd1 : track_q;
  assign track_dn  = (track_q != 8'd0) ? track_q - 8'd1 : track_q;
  assign cru_bit   = item_q.address[2:0];
  assign even_addr = {item_q.address[15:1], 1'b0};
  assign upd       = item_q.wdata[fdc_regs_pkg::CmdUpdBit];

  always_comb begin
    track_d  = track_q;
    sector_d = sector_q;
    data_d   = data_q;
    dir_d    = dir_q;
    drive_d  = drive_q;
    side_d   = side_q;
    rom_d    = rom_q;
    rdata    = 8'd0;
    if (valid_q) begin
      case (fdc_regs_pkg::req_type_e'(item_q.req_type))
        fdc_regs_pkg::REQ_CRU_RD: begin
          case (fdc_regs_pkg::cru_bit_e'(cru_bit))
            fdc_regs_pkg::CRU_DRV0: rdata = {7'd0, drive_q == 2'd0};
            fdc_regs_pkg::CRU_DRV1: rdata = {7'd0, drive_q == 2'd1};
            fdc_regs_pkg::CRU_DRV2: rdata = {7'd0, drive_q == 2'd2};
            fdc_regs_pkg::CRU_SEL2: rdata = 8'd1;
            fdc_regs_pkg::CRU_SIDE: rdata = {7'd0, side_q};
            default:                rdata = 8'd0;
          endcase
        end
        fdc_regs_pkg::REQ_CRU_WR: begin
          case (fdc_regs_pkg::cru_bit_e'(cru_bit))
            fdc_regs_pkg::CRU_ROM:  rom_d   = |item_q.wdata;
            fdc_regs_pkg::CRU_SEL0: drive_d = 2'd0;
            fdc_regs_pkg::CRU_SEL1: drive_d = 2'd1;
            fdc_regs_pkg::CRU_SEL2: drive_d = 2'd2;
            fdc_regs_pkg::CRU_SIDE: side_d  = |item_q.wdata;
            default: ;
          endcase
        end
        fdc_regs_pkg::REQ_MEM_RD: begin
          if (item_q.address >= fdc_regs_pkg::WinCmd) begin
            rdata = fdc_regs_pkg::ReadHigh;
          end else begin
            case (even_addr)
              fdc_regs_pkg::WinStatus: rdata = ~(fdc_regs_pkg::StBase |
                                         ((track_q == 8'd0) ? fdc_regs_pkg::StTrk0 : 8'd0));
              fdc_regs_pkg::WinTrack:  rdata = track_q;
              fdc_regs_pkg::WinSector: rdata = sector_q;
              fdc_regs_pkg::WinData:   rdata = data_q;
              default:                 rdata = 8'd0;
            endcase
          end
        end
        default: begin
          if (item_q.address[15:3] == fdc_regs_pkg::WinCmd[15:3]) begin
            case (fdc_regs_pkg::wr_sel_e'(item_q.address[2:1]))
              fdc_regs_pkg::WR_COMMAND: begin
                case (item_q.wdata[7:5])
                  fdc_regs_pkg::CMD_RESTORE: track_d = upd ? data_q : 8'd0;
                  fdc_regs_pkg::CMD_STEP: begin
                    if (upd) begin
                      track_d = dir_q ? track_up : track_dn;
                    end
                  end
                  fdc_regs_pkg::CMD_STEP_IN: begin
                    dir_d = 1'b1;
                    if (upd) begin
                      track_d = track_up;
                    end
                  end
                  fdc_regs_pkg::CMD_STEP_OUT: begin
                    dir_d = 1'b0;
                    if (upd) begin
                      track_d = track_dn;
                    end
                  end
                  default: ;
                endcase
              end
              fdc_regs_pkg::WR_TRACK:  track_d  = item_q.wdata;
              fdc_regs_pkg::WR_SECTOR: sector_d = item_q.wdata;
              default:                 data_d   = item_q.wdata;
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      res_valid_q <= 1'b0;
      track_q     <= 8'd0;
      sector_q    <= 8'd0;
      data_q      <= 8'd0;
      dir_q       <= 1'b0;
      drive_q     <= 2'd0;
      side_q      <= 1'b0;
      rom_q       <= 1'b0;
    end else begin
      valid_q     <= start && !busy;
      res_valid_q <= valid_q;
      track_q     <= track_d;
      sector_q    <= sector_d;
      data_q      <= data_d;
      dir_q       <= dir_d;
      drive_q     <= drive_d;
      side_q      <= side_d;
      rom_q       <= rom_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      item_q <= req_i;
    end
    if (valid_q) begin
      res_q.rdata      <= rdata;
      res_q.rom_mapped <= rom_d;
      res_q.drive_now  <= drive_d;
      res_q.side_now   <= side_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 res_valid_o)
    else $error("Accepted transaction produced no result.");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.drive_now != 2'd3))
    else $error("Result reports an unused drive code.");

  a_track_write_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(track_q) |-> $past(valid_q &&
      item_q.req_type == fdc_regs_pkg::REQ_MEM_WR))
    else $error("Track register changed without a memory write.");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(valid_q))
    else $error("Result strobe without a pending transaction.");
`endif

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned RandomItems = 1300;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned QuietFirst = 300;
  localparam int unsigned QuietLast = 650;
  localparam int unsigned DrainAt = 900;
  localparam int unsigned IdlePercent = 18;
  localparam int unsigned SettleCycles = 4;
  localparam logic [7:0] IgnoredCmd = 8'hF0;

  class fdc_register_tracker;
    logic [7:0] track;
    logic [7:0] sector;
    logic [7:0] data_byte;
    logic step_away;
    logic [1:0] drive;
    logic side;
    logic rom_on;
    fdc_regs_pkg::res_t pending_replies[$];
    int unsigned mismatches;

    function new();
      track = '0;
      sector = '0;
      data_byte = '0;
      step_away = 1'b0;
      drive = '0;
      side = 1'b0;
      rom_on = 1'b0;
      mismatches = 0;
    endfunction

    function void track_up();
      if (track != fdc_regs_pkg::TrackMax) track = track + 8'd1;
    endfunction

    function void track_down();
      if (track != 8'd0) track = track - 8'd1;
    endfunction

    function logic [7:0] cru_read(logic [15:0] addr);
      case (addr[2:0])
        fdc_regs_pkg::CRU_DRV0: return {7'd0, drive == 2'd0};
        fdc_regs_pkg::CRU_DRV1: return {7'd0, drive == 2'd1};
        fdc_regs_pkg::CRU_DRV2: return {7'd0, drive == 2'd2};
        fdc_regs_pkg::CRU_SEL2: return 8'd1;
        fdc_regs_pkg::CRU_SIDE: return {7'd0, side};
        default: return 8'd0;
      endcase
    endfunction

    function void cru_write(logic [15:0] addr, logic [7:0] wdata);
      case (addr[2:0])
        fdc_regs_pkg::CRU_ROM: rom_on = (wdata != 8'd0);
        fdc_regs_pkg::CRU_SEL0: drive = 2'd0;
        fdc_regs_pkg::CRU_SEL1: drive = 2'd1;
        fdc_regs_pkg::CRU_SEL2: drive = 2'd2;
        fdc_regs_pkg::CRU_SIDE: side = (wdata != 8'd0);
        default: ;
      endcase
    endfunction

    function logic [7:0] mem_read(logic [15:0] addr);
      if (addr >= fdc_regs_pkg::WinCmd) return fdc_regs_pkg::ReadHigh;
      case ({addr[15:1], 1'b0})
        fdc_regs_pkg::WinStatus:
          return ~(fdc_regs_pkg::StBase | ((track == 8'd0) ? fdc_regs_pkg::StTrk0 : 8'd0));
        fdc_regs_pkg::WinTrack: return track;
        fdc_regs_pkg::WinSector: return sector;
        fdc_regs_pkg::WinData: return data_byte;
        default: return 8'd0;
      endcase
    endfunction

    function void run_command(logic [7:0] wdata);
      logic upd;
      upd = wdata[fdc_regs_pkg::CmdUpdBit];
      case (wdata[7:5])
        fdc_regs_pkg::CMD_RESTORE: track = upd ? data_byte : 8'd0;
        fdc_regs_pkg::CMD_STEP: begin
          if (upd) begin
            if (step_away) track_up();
            else track_down();
          end
        end
        fdc_regs_pkg::CMD_STEP_IN: begin
          step_away = 1'b1;
          if (upd) track_up();
        end
        fdc_regs_pkg::CMD_STEP_OUT: begin
          step_away = 1'b0;
          if (upd) track_down();
        end
        default: ;
      endcase
    endfunction

    function void mem_write(logic [15:0] addr, logic [7:0] wdata);
      if (addr[15:3] != fdc_regs_pkg::WinCmd[15:3]) return;
      case (addr[2:1])
        fdc_regs_pkg::WR_COMMAND: run_command(wdata);
        fdc_regs_pkg::WR_TRACK: track = wdata;
        fdc_regs_pkg::WR_SECTOR: sector = wdata;
        fdc_regs_pkg::WR_DATA: data_byte = wdata;
        default: ;
      endcase
    endfunction

    function void note_access(fdc_regs_pkg::req_t r);
      fdc_regs_pkg::res_t reply;
      reply.rdata = 8'd0;
      case (r.req_type)
        fdc_regs_pkg::REQ_CRU_RD: reply.rdata = cru_read(r.address);
        fdc_regs_pkg::REQ_CRU_WR: cru_write(r.address, r.wdata);
        fdc_regs_pkg::REQ_MEM_RD: reply.rdata = mem_read(r.address);
        default: mem_write(r.address, r.wdata);
      endcase
      reply.rom_mapped = rom_on;
      reply.drive_now = drive;
      reply.side_now = side;
      pending_replies.push_back(reply);
    endfunction

    function void check_reply(fdc_regs_pkg::res_t got);
      fdc_regs_pkg::res_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected result: rdata %0h", got.rdata);
        mismatches++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.rdata !== want.rdata) begin
        $error("rdata: expected %0h, actual %0h", want.rdata, got.rdata);
        mismatches++;
      end
      if (got.rom_mapped !== want.rom_mapped) begin
        $error("rom_mapped: expected %0h, actual %0h", want.rom_mapped, got.rom_mapped);
        mismatches++;
      end
      if (got.drive_now !== want.drive_now) begin
        $error("drive_now: expected %0h, actual %0h", want.drive_now, got.drive_now);
        mismatches++;
      end
      if (got.side_now !== want.side_now) begin
        $error("side_now: expected %0h, actual %0h", want.side_now, got.side_now);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  fdc_regs_pkg::req_t req_i;
  logic res_valid_o;
  fdc_regs_pkg::res_t res_o;
  int unsigned cycle_count = 0;

  fdc_register_tracker tracker = new();

  floppy_controller_registers_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .res_valid_o(res_valid_o),
    .res_o(res_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) tracker.note_access(req_i);
      if (res_valid_o) tracker.check_reply(res_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("floppy_controller_registers_unit test failed");
      $finish;
    end
  end

  function automatic fdc_regs_pkg::req_t make_req(fdc_regs_pkg::req_type_e kind,
                                                  logic [15:0] addr, logic [7:0] wdata);
    fdc_regs_pkg::req_t r;
    r.req_type = kind;
    r.address = addr;
    r.wdata = wdata;
    return r;
  endfunction

  function automatic logic [15:0] cru_addr(fdc_regs_pkg::cru_bit_e b, logic [12:0] upper);
    return {upper, b};
  endfunction

  function automatic logic [7:0] cmd_byte(fdc_regs_pkg::cmd_e c, logic upd);
    return {c, upd, 4'h0};
  endfunction

  function automatic fdc_regs_pkg::req_t random_req();
    fdc_regs_pkg::req_t r;
    int unsigned pick;
    r.req_type = fdc_regs_pkg::req_type_e'($urandom_range(0, 3));
    r.wdata = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (r.req_type == fdc_regs_pkg::REQ_CRU_RD || r.req_type == fdc_regs_pkg::REQ_CRU_WR) begin
      r.address = 16'($urandom_range(0, 65535));
      if (r.req_type == fdc_regs_pkg::REQ_CRU_WR && pick < 30) r.wdata = 8'd0;
    end else begin
      if (pick < 70) begin
        r.address = fdc_regs_pkg::WinStatus + 16'($urandom_range(0, 15));
      end else if (pick < 80) begin
        r.address = fdc_regs_pkg::WinStatus - 16'd16 + 16'($urandom_range(0, 47));
      end else begin
        r.address = 16'($urandom_range(0, 65535));
      end
      if (r.req_type == fdc_regs_pkg::REQ_MEM_WR && $urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: r.wdata = 8'd0;
          1: r.wdata = 8'd1;
          2: r.wdata = fdc_regs_pkg::TrackMax - 8'd1;
          default: r.wdata = fdc_regs_pkg::TrackMax;
        endcase
      end
    end
    return r;
  endfunction

  task automatic send_request(fdc_regs_pkg::req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    idle_cycle();
    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    start <= 1'b0;
    req_i <= '0;
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(make_req(fdc_regs_pkg::REQ_CRU_RD,
                          cru_addr(fdc_regs_pkg::CRU_DRV0, 13'h1FFF), 8'h00));
    send_request(make_req(fdc_regs_pkg::REQ_CRU_WR,
                          cru_addr(fdc_regs_pkg::CRU_ROM, 13'h0000), 8'h80));
    send_request(make_req(fdc_regs_pkg::REQ_CRU_WR,
                          cru_addr(fdc_regs_pkg::CRU_SEL1, 13'h0AAA), 8'h00));
    send_request(make_req(fdc_regs_pkg::REQ_CRU_RD,
                          cru_addr(fdc_regs_pkg::CRU_DRV1, 13'h1555), 8'hFF));
    send_request(make_req(fdc_regs_pkg::REQ_CRU_WR,
                          cru_addr(fdc_regs_pkg::CRU_SEL2, 13'h0001), 8'hFF));
    send_request(make_req(fdc_regs_pkg::REQ_CRU_RD,
                          cru_addr(fdc_regs_pkg::CRU_DRV2, 13'h0000), 8'h00));
    send_request(make_req(fdc_regs_pkg::REQ_CRU_WR,
                          cru_addr(fdc_regs_pkg::CRU_SIDE, 13'h0000), 8'h01));
    send_request(make_req(fdc_regs_pkg::REQ_CRU_RD,
                          cru_addr(fdc_regs_pkg::CRU_SIDE, 13'h0000), 8'h00));
    send_request(make_req(fdc_regs_pkg::REQ_CRU_RD,
                          cru_addr(fdc_regs_pkg::CRU_SEL2, 13'h0000), 8'h00));
    send_request(make_req(fdc_regs_pkg::REQ_CRU_WR,
                          cru_addr(fdc_regs_pkg::CRU_DRV1, 13'h0000), 8'hFF));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_RD, fdc_regs_pkg::WinStatus + 16'd1, 8'h00));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_WR, fdc_regs_pkg::WinCmd + 16'd2,
                          fdc_regs_pkg::TrackMax - 8'd1));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_WR, fdc_regs_pkg::WinCmd,
                          cmd_byte(fdc_regs_pkg::CMD_STEP_IN, 1'b1)));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_WR, fdc_regs_pkg::WinCmd + 16'd1,
                          cmd_byte(fdc_regs_pkg::CMD_STEP_IN, 1'b1)));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_RD, fdc_regs_pkg::WinTrack + 16'd1, 8'h00));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_WR, fdc_regs_pkg::WinCmd,
                          cmd_byte(fdc_regs_pkg::CMD_STEP, 1'b1)));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_WR, fdc_regs_pkg::WinCmd,
                          cmd_byte(fdc_regs_pkg::CMD_STEP_OUT, 1'b0)));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_WR, fdc_regs_pkg::WinCmd + 16'd7, 8'h01));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_WR, fdc_regs_pkg::WinCmd,
                          cmd_byte(fdc_regs_pkg::CMD_RESTORE, 1'b1)));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_WR, fdc_regs_pkg::WinCmd,
                          cmd_byte(fdc_regs_pkg::CMD_STEP, 1'b1)));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_WR, fdc_regs_pkg::WinCmd,
                          cmd_byte(fdc_regs_pkg::CMD_STEP_OUT, 1'b1)));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_RD, fdc_regs_pkg::WinStatus, 8'h00));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_WR, fdc_regs_pkg::WinCmd, IgnoredCmd));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_WR, fdc_regs_pkg::WinCmd + 16'd4, 8'hA5));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_RD, fdc_regs_pkg::WinSector, 8'h00));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_RD, fdc_regs_pkg::WinData, 8'h00));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_RD, 16'hFFFF, 8'h00));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_WR, fdc_regs_pkg::WinStatus, 8'h5A));
    send_request(make_req(fdc_regs_pkg::REQ_MEM_RD, 16'h0000, 8'h00));
    drain_results();

    for (int unsigned i = 0; i < RandomItems; i++) begin
      if (i == DrainAt) drain_results();
      if (i < QuietFirst || i > QuietLast) begin
        while ($urandom_range(0, 99) < IdlePercent) idle_cycle();
      end
      send_request(random_req());
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("floppy_controller_registers_unit test passed");
    end else begin
      $display("floppy_controller_registers_unit test failed");
    end
    $finish;
  end

endmodule
